FILE: rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ffma_pkg.sv
// Shared types and constants of the first-fit allocator.
// No dependencies.
package ffma_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int WAIT_DEPTH_DEF = 16;

  localparam int TIME_W = 31;
  localparam int END_W  = 32;
  localparam int LEN_W  = 16;
  localparam int IDX_W  = 16;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;

  localparam logic REG_MEMORY_SIZE      = 1'b0;
  localparam logic REG_REPORT_PLACEMENTS = 1'b1;

  localparam logic KIND_PLACEMENT = 1'b0;
  localparam logic KIND_SUMMARY   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] event_time;
    logic [IDX_W-1:0]  proc_index;
    logic [LEN_W-1:0]  position;
    logic [15:0]       waited_count;
    logic              queue_overflow;
  } res_t;

endpackage

FILE: rtl/ffma_outbuf.sv
// Result holding stage and output register; marks the last word of an item.
// Depends on ffma_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffma_outbuf
  import ffma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  res_t                  push_res,
  input  logic                  flush,
  output logic                  ok,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // event_time[30:0], proc_index[46:31], position[62:47], waited_count[78:63],
  // queue_overflow[79]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // kind
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  logic pend_valid;
  res_t pend;
  res_t out_res;
  logic out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign ok       = !pend_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (push && ok) begin
        pend       <= push_res;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_res       <= pend;
          m_axis_tlast  <= 1'b0;
          m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
        end
      end else if (flush && ok && pend_valid) begin
        out_res       <= pend;
        m_axis_tlast  <= 1'b1;
        m_axis_tvalid <= 1'b1;
        pend_valid    <= 1'b0;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {out_res.queue_overflow, out_res.waited_count, out_res.position,
                         out_res.proc_index, out_res.event_time};

  `ASSERT_NEXT(a_push_held, push && ok, pend_valid, "pushed word not held")
  `ASSERT_NEXT(a_flush_empty, flush && ok, !pend_valid, "flush left a word behind")
  `ASSERT_NEXT(a_mid_word, push && ok && pend_valid, m_axis_tvalid && !m_axis_tlast,
               "earlier word not sent as non-final")

endmodule

FILE: rtl/first_fit_memory_allocator.sv
// First-fit allocator with a FIFO wait queue; block table and queue in memories.
// Depends on ffma_pkg, ffma_outbuf and assert_macros.svh.
//
// channel  dir  tdata                                         tuser     tlast
// s_axis   in   arrive_time, mem_len, run_time                req_type  -
// m_axis   out  event_time, proc_index, position, waited, ovf kind      last_of_run
// cfg      in   cfg_addr selects memory_size / report_placements
//
// One item at a time; s_axis_tready is high only when idle. A table scan reads one
// entry per cycle from the block memory and checks each registered entry in turn.
// An arrival first releases due blocks group by group, retrying the wait queue after
// each release group; a queue retry or the arrival then runs fit passes, each a table
// scan while the candidate fits memory_size, until a gap fits or the placement fails.
// Results wait in one holding register; a new result or the final flush stalls while
// that register is full and the output word is not taken.
// Reset clears the valid bits and counters at once; no clearing pass.
`include "assert_macros.svh"

module first_fit_memory_allocator
  import ffma_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // arrive_time[30:0], mem_len[46:31], run_time[77:47]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // event_time[30:0], proc_index[46:31], position[62:47], waited_count[78:63],
  // queue_overflow[79]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // kind
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [15:0]           cfg_wdata
);

  localparam int BW = $clog2(MAX_BLOCKS);
  localparam int WW = $clog2(WAIT_DEPTH);
  localparam int CW = $clog2(WAIT_DEPTH + 1);
  localparam int BLK_W = 2 * LEN_W + END_W;
  localparam int WQ_W  = IDX_W + LEN_W + TIME_W;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_REL_START = 13'b0000000000010,
    S_REL_SCAN  = 13'b0000000000100,
    S_REL_APPLY = 13'b0000000001000,
    S_Q_RETRY   = 13'b0000000010000,
    S_Q_DATA    = 13'b0000000100000,
    S_PL_START  = 13'b0000001000000,
    S_PL_PASS   = 13'b0000010000000,
    S_FIT_SCAN  = 13'b0000100000000,
    S_PL_DONE   = 13'b0001000000000,
    S_PL_FAIL   = 13'b0010000000000,
    S_DRAIN_END = 13'b0100000000000,
    S_FLUSH     = 13'b1000000000000
  } state_t;

  state_t state;

  logic [15:0] memory_size;
  logic        report_placements;

  // request
  logic              r_drain;
  logic [TIME_W-1:0] r_t;
  logic [LEN_W-1:0]  r_len;
  logic [TIME_W-1:0] r_run;
  logic [IDX_W-1:0]  r_idx;

  // placement context
  logic [END_W-1:0]  p_t;
  logic [LEN_W-1:0]  p_len;
  logic [TIME_W-1:0] p_run;
  logic [IDX_W-1:0]  p_idx;
  logic              p_from_q;
  logic [BW-1:0]     p_slot;
  logic [LEN_W:0]    c;
  logic              ovl;
  logic [LEN_W:0]    maxend;

  // release context
  logic                  rel_any;
  logic [END_W-1:0]      rel_min;
  logic [MAX_BLOCKS-1:0] rel_mask;

  logic [MAX_BLOCKS-1:0] valid;
  logic [WW-1:0]         wait_head;
  logic [CW-1:0]         wait_count;
  logic [IDX_W-1:0]      next_index;
  logic [END_W-1:0]      last_release_time;
  logic [15:0]           waited_total;

  // memories
  logic [BLK_W-1:0] blk_mem [MAX_BLOCKS];
  logic [BLK_W-1:0] blk_rdata;
  logic [WQ_W-1:0]  wq_mem [WAIT_DEPTH];
  logic [WQ_W-1:0]  wq_rdata;
  logic             wq_rd_en;

  // scanner
  logic          sc_run;
  logic [BW-1:0] sc_addr;
  logic          chk;
  logic [BW-1:0] chk_idx;
  logic          chk_last;

  logic [LEN_W-1:0] s_start;
  logic [LEN_W-1:0] s_len;
  logic [END_W-1:0] s_end;
  logic [LEN_W:0]   s_stop;
  logic [LEN_W:0]   c_top;
  logic             chk_hit_valid;

  logic          slot_free;
  logic [BW-1:0] slot;

  logic [END_W:0]   end_sum;
  logic [END_W-1:0] end_sat;
  logic [CW:0]      tail_sum;
  logic [WW-1:0]    tail;
  logic [WW-1:0]    head_inc;

  logic push;
  logic flush;
  logic ok;
  res_t push_res;

  assign s_start = blk_rdata[LEN_W-1:0];
  assign s_len   = blk_rdata[2*LEN_W-1:LEN_W];
  assign s_end   = blk_rdata[BLK_W-1:2*LEN_W];
  assign s_stop  = {1'b0, s_start} + {1'b0, s_len};
  assign c_top   = c + {1'b0, p_len};
  assign chk_hit_valid = chk && valid[chk_idx];

  always_comb begin
    slot = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        slot = BW'(i);
      end
    end
  end
  assign slot_free = !(&valid);

  assign end_sum = {1'b0, p_t} + {2'b0, p_run};
  assign end_sat = end_sum[END_W] ? '1 : end_sum[END_W-1:0];

  assign tail_sum = (CW+1)'(wait_head) + (CW+1)'(wait_count);
  assign tail = (tail_sum >= (CW+1)'(WAIT_DEPTH)) ?
                WW'(tail_sum - (CW+1)'(WAIT_DEPTH)) : WW'(tail_sum);
  assign head_inc = (wait_head == WW'(WAIT_DEPTH - 1)) ? '0 : wait_head + 1'b1;

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size       <= 16'hFFFF;
      report_placements <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MEMORY_SIZE:       memory_size <= cfg_wdata;
        REG_REPORT_PLACEMENTS: report_placements <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // block table and wait queue memories
  always_ff @(posedge clk) begin
    if (sc_run) begin
      blk_rdata <= blk_mem[sc_addr];
    end
    if (state == S_PL_DONE && !(push && !ok) && p_run != '0) begin
      blk_mem[p_slot] <= {end_sat, p_len, c[LEN_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (wq_rd_en) begin
      wq_rdata <= wq_mem[wait_head];
    end
    if (state == S_PL_FAIL && !p_from_q && wait_count != CW'(WAIT_DEPTH)) begin
      wq_mem[tail] <= {r_run, r_len, r_idx};
    end
  end

  assign wq_rd_en = (state == S_Q_RETRY) && (wait_count != '0);

  // scanner: one read per cycle, checked in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_run <= 1'b0;
      chk    <= 1'b0;
    end else begin
      chk      <= sc_run;
      chk_idx  <= sc_addr;
      chk_last <= (sc_addr == BW'(MAX_BLOCKS - 1));
      if (state == S_REL_START || (state == S_PL_PASS && c_top <= {1'b0, memory_size})) begin
        sc_run  <= 1'b1;
        sc_addr <= '0;
      end else if (sc_run) begin
        if (sc_addr == BW'(MAX_BLOCKS - 1)) begin
          sc_run <= 1'b0;
        end else begin
          sc_addr <= sc_addr + 1'b1;
        end
      end
    end
  end

  // result selection
  always_comb begin
    push     = 1'b0;
    push_res = '0;
    flush    = (state == S_FLUSH);
    case (state)
      S_PL_DONE: begin
        push                = report_placements;
        push_res.kind       = KIND_PLACEMENT;
        push_res.event_time = p_t[TIME_W-1:0];
        push_res.proc_index = p_idx;
        push_res.position   = c[LEN_W-1:0];
      end
      S_PL_FAIL: begin
        push                    = !p_from_q && (wait_count == CW'(WAIT_DEPTH));
        push_res.kind           = KIND_PLACEMENT;
        push_res.event_time     = r_t;
        push_res.proc_index     = r_idx;
        push_res.queue_overflow = 1'b1;
      end
      S_DRAIN_END: begin
        push                  = 1'b1;
        push_res.kind         = KIND_SUMMARY;
        push_res.event_time   = last_release_time[TIME_W-1:0];
        push_res.waited_count = waited_total;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      valid             <= '0;
      wait_head         <= '0;
      wait_count        <= '0;
      next_index        <= IDX_W'(1);
      last_release_time <= '0;
      waited_total      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            r_drain <= s_axis_tuser;
            r_t     <= s_axis_tdata[30:0];
            r_len   <= s_axis_tdata[46:31];
            r_run   <= s_axis_tdata[77:47];
            r_idx   <= next_index;
            if (!s_axis_tuser) begin
              next_index <= next_index + 1'b1;
            end
            state <= S_REL_START;
          end
        end
        S_REL_START: begin
          rel_any  <= 1'b0;
          rel_mask <= '0;
          state    <= S_REL_SCAN;
        end
        S_REL_SCAN: begin
          if (chk_hit_valid && (r_drain || s_end <= {1'b0, r_t})) begin
            if (!rel_any || s_end < rel_min) begin
              rel_any  <= 1'b1;
              rel_min  <= s_end;
              rel_mask <= MAX_BLOCKS'(1) << chk_idx;
            end else if (s_end == rel_min) begin
              rel_mask <= rel_mask | (MAX_BLOCKS'(1) << chk_idx);
            end
          end
          if (chk && chk_last) begin
            state <= S_REL_APPLY;
          end
        end
        S_REL_APPLY: begin
          if (rel_any) begin
            valid             <= valid & ~rel_mask;
            last_release_time <= rel_min;
            p_t               <= rel_min;
            state             <= S_Q_RETRY;
          end else if (r_drain) begin
            state <= S_DRAIN_END;
          end else begin
            p_t      <= {1'b0, r_t};
            p_len    <= r_len;
            p_run    <= r_run;
            p_idx    <= r_idx;
            p_from_q <= 1'b0;
            state    <= S_PL_START;
          end
        end
        S_Q_RETRY: begin
          state <= (wait_count == '0) ? S_REL_START : S_Q_DATA;
        end
        S_Q_DATA: begin
          p_idx    <= wq_rdata[IDX_W-1:0];
          p_len    <= wq_rdata[IDX_W+LEN_W-1:IDX_W];
          p_run    <= wq_rdata[WQ_W-1:IDX_W+LEN_W];
          p_from_q <= 1'b1;
          state    <= S_PL_START;
        end
        S_PL_START: begin
          p_slot <= slot;
          c      <= '0;
          state  <= slot_free ? S_PL_PASS : S_PL_FAIL;
        end
        S_PL_PASS: begin
          ovl    <= 1'b0;
          maxend <= '0;
          state  <= (c_top <= {1'b0, memory_size}) ? S_FIT_SCAN : S_PL_FAIL;
        end
        S_FIT_SCAN: begin
          if (chk_hit_valid && {1'b0, s_start} < c_top && c < s_stop) begin
            ovl <= 1'b1;
            if (s_stop > maxend) begin
              maxend <= s_stop;
            end
          end
          if (chk && chk_last) begin
            state <= S_PL_DONE;
          end
        end
        S_PL_DONE: begin
          if (ovl) begin
            c     <= maxend;
            state <= S_PL_PASS;
          end else if (!(push && !ok)) begin
            if (p_run != '0) begin
              valid[p_slot] <= 1'b1;
            end
            if (p_from_q) begin
              wait_head  <= head_inc;
              wait_count <= wait_count - 1'b1;
              state      <= S_Q_RETRY;
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_PL_FAIL: begin
          if (p_from_q) begin
            state <= S_REL_START;
          end else if (!(push && !ok)) begin
            if (waited_total != 16'hFFFF) begin
              waited_total <= waited_total + 1'b1;
            end
            if (wait_count != CW'(WAIT_DEPTH)) begin
              wait_count <= wait_count + 1'b1;
            end
            state <= S_FLUSH;
          end
        end
        S_DRAIN_END: begin
          if (ok) begin
            valid             <= '0;
            wait_head         <= '0;
            wait_count        <= '0;
            next_index        <= IDX_W'(1);
            last_release_time <= '0;
            waited_total      <= '0;
            state             <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ffma_outbuf u_outbuf (
    .clk           (clk),
    .rst           (rst),
    .push          (push && !(state == S_PL_DONE && ovl)),
    .push_res      (push_res),
    .flush         (flush),
    .ok            (ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `ASSERT_CLK(a_wait_bound, wait_count <= CW'(WAIT_DEPTH), "wait queue count out of range")
  `ASSERT_NEXT(a_drain_clears, state == S_DRAIN_END && ok,
               valid == '0 && wait_count == '0, "drain left live state")

endmodule

FILE: bench/tb_first_fit_memory_allocator.sv
// Testbench for first_fit_memory_allocator: drives request words, predicts every
// result with a behavioral allocator model and checks the output stream.
// Depends on ffma_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_first_fit_memory_allocator;
  import ffma_pkg::*;

  localparam int NBLK = 16;
  localparam int NWAIT = 16;

  typedef struct {
    logic        kind;
    logic [30:0] etime;
    logic [15:0] pidx;
    logic [15:0] pos;
    logic [15:0] waited;
    logic        ovf;
    logic        last;
  } alloc_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;

  first_fit_memory_allocator dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // allocator model state
  logic [15:0] mem_size;
  logic        report_on;
  logic        blk_used [NBLK];
  logic [31:0] blk_start [NBLK];
  logic [31:0] blk_len [NBLK];
  logic [31:0] blk_end [NBLK];
  logic [31:0] wq_proc [NWAIT];
  logic [31:0] wq_len [NWAIT];
  logic [31:0] wq_run [NWAIT];
  int unsigned wq_head, wq_cnt;
  logic [15:0] proc_next;
  logic [31:0] last_rel;
  logic [15:0] waited_tot;

  alloc_res_t pending_res[$];
  alloc_res_t step_res[$];
  int errors = 0;
  int n_results = 0;
  int n_summaries = 0;
  int n_ovf = 0;
  int idle_in = 0;
  int idle_out = 0;
  logic hold_on = 1'b0;
  logic [30:0] cur_time;

  task automatic model_clear();
    for (int k = 0; k < NBLK; k++) blk_used[k] = 1'b0;
    wq_head = 0;
    wq_cnt = 0;
    proc_next = 16'd1;
    last_rel = '0;
    waited_tot = '0;
  endtask

  task automatic push_res(logic kind, logic [31:0] t, logic [15:0] idx, logic [15:0] pos,
                          logic [15:0] w, logic ovf);
    alloc_res_t r;
    r.kind = kind;
    r.etime = t[30:0];
    r.pidx = idx;
    r.pos = pos;
    r.waited = w;
    r.ovf = ovf;
    r.last = 1'b0;
    step_res.push_back(r);
  endtask

  function automatic bit gap_free(logic [31:0] c, logic [31:0] len);
    if (c + len > {16'd0, mem_size}) return 0;
    for (int j = 0; j < NBLK; j++)
      if (blk_used[j] && blk_start[j] < c + len && c < blk_start[j] + blk_len[j]) return 0;
    return 1;
  endfunction

  function automatic bit try_place(logic [31:0] len, logic [31:0] run, logic [31:0] t,
                                   output logic [31:0] pos);
    int slot;
    bit found;
    logic [31:0] best, c, e;
    slot = -1;
    found = 0;
    best = '0;
    pos = '0;
    for (int k = NBLK - 1; k >= 0; k--) if (!blk_used[k]) slot = k;
    if (slot < 0) return 0;
    if (gap_free(32'd0, len)) found = 1;
    else begin
      for (int k = 0; k < NBLK; k++) begin
        if (!blk_used[k]) continue;
        c = blk_start[k] + blk_len[k];
        if ((!found || c < best) && gap_free(c, len)) begin
          best = c;
          found = 1;
        end
      end
    end
    if (!found) return 0;
    pos = best;
    if (run != 0) begin
      e = t + run;
      if (e < t) e = 32'hFFFF_FFFF;
      blk_used[slot] = 1'b1;
      blk_start[slot] = best;
      blk_len[slot] = len;
      blk_end[slot] = e;
    end
    return 1;
  endfunction

  task automatic retry_waiting(logic [31:0] t);
    logic [31:0] pos;
    while (wq_cnt > 0) begin
      if (!try_place(wq_len[wq_head], wq_run[wq_head], t, pos)) break;
      if (report_on)
        push_res(KIND_PLACEMENT, t, wq_proc[wq_head][15:0], pos[15:0], 16'd0, 1'b0);
      wq_head = (wq_head + 1) % NWAIT;
      wq_cnt--;
    end
  endtask

  task automatic release_until(bit bounded, logic [31:0] lim);
    bit any;
    logic [31:0] m;
    forever begin
      any = 0;
      m = '0;
      for (int k = 0; k < NBLK; k++)
        if (blk_used[k] && (!bounded || blk_end[k] <= lim) && (!any || blk_end[k] < m)) begin
          m = blk_end[k];
          any = 1;
        end
      if (!any) break;
      for (int k = 0; k < NBLK; k++) if (blk_used[k] && blk_end[k] == m) blk_used[k] = 1'b0;
      last_rel = m;
      retry_waiting(m);
    end
  endtask

  task automatic predict_request(logic drain, logic [30:0] t, logic [15:0] len, logic [30:0] run);
    logic [15:0] idx;
    logic [31:0] pos;
    int unsigned tail;
    step_res.delete();
    if (drain) begin
      release_until(1'b0, 32'd0);
      push_res(KIND_SUMMARY, last_rel, 16'd0, 16'd0, waited_tot, 1'b0);
      model_clear();
    end else begin
      idx = proc_next;
      proc_next = proc_next + 16'd1;
      release_until(1'b1, {1'b0, t});
      if (try_place({16'd0, len}, {1'b0, run}, {1'b0, t}, pos)) begin
        if (report_on) push_res(KIND_PLACEMENT, {1'b0, t}, idx, pos[15:0], 16'd0, 1'b0);
      end else begin
        if (waited_tot != 16'hFFFF) waited_tot++;
        if (wq_cnt < NWAIT) begin
          tail = (wq_head + wq_cnt) % NWAIT;
          wq_proc[tail] = {16'd0, idx};
          wq_len[tail] = {16'd0, len};
          wq_run[tail] = {1'b0, run};
          wq_cnt++;
        end else push_res(KIND_PLACEMENT, {1'b0, t}, idx, 16'd0, 16'd0, 1'b1);
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) pending_res.push_back(step_res[i]);
  endtask

  task automatic send_word(logic drain, logic [30:0] t, logic [15:0] len, logic [30:0] run);
    while (idle_in > 0 && $urandom_range(99) < idle_in) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= drain;
    s_axis_tdata <= {2'b00, run, len, t};
    predict_request(drain, t, len, run);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic arrive(logic [15:0] len, logic [30:0] run, int unsigned dt = 0);
    cur_time = cur_time + 31'(dt);
    send_word(1'b0, cur_time, len, run);
  endtask

  task automatic drain_batch();
    send_word(1'b1, 31'($urandom), 16'($urandom), 31'($urandom));
    cur_time = 31'($urandom_range(0, 3));
  endtask

  task automatic wait_idle();
    while (pending_res.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MEMORY_SIZE) mem_size = val;
    else report_on = val[0];
    @(posedge clk);
  endtask

  task automatic hold_receiver(int n);
    hold_on <= 1'b1;
    repeat (n) @(posedge clk);
    hold_on <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        alloc_res_t ex;
        n_results++;
        if (pending_res.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          errors++;
        end else begin
          ex = pending_res.pop_front();
          if (m_axis_tuser) n_summaries++;
          if (m_axis_tdata[79]) n_ovf++;
          if (m_axis_tuser !== ex.kind) begin
            $error("kind exp %0d got %0d", ex.kind, m_axis_tuser); errors++;
          end
          if (m_axis_tdata[30:0] !== ex.etime) begin
            $error("event_time exp %0d got %0d", ex.etime, m_axis_tdata[30:0]); errors++;
          end
          if (m_axis_tdata[46:31] !== ex.pidx) begin
            $error("proc_index exp %0d got %0d", ex.pidx, m_axis_tdata[46:31]); errors++;
          end
          if (m_axis_tdata[62:47] !== ex.pos) begin
            $error("position exp %0d got %0d", ex.pos, m_axis_tdata[62:47]); errors++;
          end
          if (m_axis_tdata[78:63] !== ex.waited) begin
            $error("waited_count exp %0d got %0d", ex.waited, m_axis_tdata[78:63]); errors++;
          end
          if (m_axis_tdata[79] !== ex.ovf) begin
            $error("queue_overflow exp %0d got %0d", ex.ovf, m_axis_tdata[79]); errors++;
          end
          if (m_axis_tlast !== ex.last) begin
            $error("last_of_run exp %0d got %0d", ex.last, m_axis_tlast); errors++;
          end
        end
      end
    end
  end

  // receiver readiness
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_on) m_axis_tready <= 1'b0;
      else m_axis_tready <= ($urandom_range(99) >= idle_out);
    end
  end

  task automatic test_directed();
    write_reg(REG_MEMORY_SIZE, 16'd100);
    write_reg(REG_REPORT_PLACEMENTS, 16'd1);
    cur_time = '0;
    arrive(16'd40, 31'd10);
    arrive(16'd0, 31'd5);
    arrive(16'd60, 31'd0);
    arrive(16'd60, 31'd20, 1);
    arrive(16'd30, 31'd3, 1);
    arrive(16'd101, 31'd1);
    arrive(16'd10, 31'h7FFF_FFFF, 20);
    send_word(1'b0, 31'h7FFF_FFFF, 16'd5, 31'h7FFF_FFFF);
    arrive(16'hFFFF, 31'd1);
    drain_batch();
    for (int i = 0; i < 17; i++) arrive(16'd1, 31'd50);
    arrive(16'd200, 31'd1);
    drain_batch();
    wait_idle();
    write_reg(REG_MEMORY_SIZE, 16'd0);
    arrive(16'd1, 31'd1);
    arrive(16'd0, 31'd1);
    drain_batch();
    wait_idle();
  endtask

  task automatic random_phase(int n, int unsigned msz, bit rep, int pin, int pout);
    int sel;
    wait_idle();
    write_reg(REG_MEMORY_SIZE, msz[15:0]);
    write_reg(REG_REPORT_PLACEMENTS, {15'd0, rep});
    idle_in = pin;
    idle_out = pout;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 4) drain_batch();
      else if (sel < 6)
        send_word(1'b0, 31'($urandom), 16'($urandom), 31'($urandom));
      else if (sel < 9)
        arrive(16'($urandom_range(0, 65535)), 31'($urandom_range(0, 31'h7FFF_FFFF)),
               $urandom_range(0, 3));
      else
        arrive(16'($urandom_range(0, msz / 3 + 1)), 31'($urandom_range(0, 40)),
               $urandom_range(0, 8));
    end
    drain_batch();
  endtask

  task automatic test_backpressure();
    wait_idle();
    idle_in = 0;
    fork
      hold_receiver(400);
    join_none
    for (int i = 0; i < 20; i++)
      arrive(16'($urandom_range(1, 20)), 31'($urandom_range(1, 30)), 1);
    drain_batch();
    wait_idle();
  endtask

  initial begin
    mem_size = 16'hFFFF;
    report_on = 1'b1;
    model_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    random_phase(90, 100, 1, 0, 0);
    random_phase(70, 60, 1, 83, 0);
    random_phase(70, 200, 0, 0, 83);
    random_phase(70, 65535, 1, 21, 21);
    random_phase(40, 1, 1, 0, 0);
    test_backpressure();
    idle_in = 0;
    idle_out = 0;
    wait_idle();
    $display("Covered directed edge cases, %0d results, %0d summaries, %0d overflows,",
             n_results, n_summaries, n_ovf);
    $display("under several memory sizes, report modes and stall mixes.");
    if (errors == 0 && pending_res.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ffma_pkg.sv
rtl/ffma_outbuf.sv
rtl/first_fit_memory_allocator.sv
bench/tb_first_fit_memory_allocator.sv
